// ----- hw/rtl/crt4x_pkg.sv -----
// ----------------------------------------------------------------------------
// CRT 4x upscaler package
// Shared types, register map codes, reset values and arithmetic constants.
// ----------------------------------------------------------------------------
`default_nettype none

package crt4x_pkg;

	// Default depth of the row store, in source pixels.
	localparam int MAX_WIDTH_DEF = 1024;

	// Field widths.
	localparam int CH_W        = 8;
	localparam int ACTIVE_W    = 11;
	localparam int FADE_W      = 17;
	localparam int OUT_COL_W   = 12;
	localparam int NUM_FADE    = 6;
	localparam int PADDR_W     = 5;
	localparam int PDATA_W     = 32;

	// Command codes carried in the input tuser.
	localparam logic CMD_PUSH   = 1'b0;
	localparam logic CMD_REPLAY = 1'b1;

	// Output row codes.
	localparam logic [1:0] ROW_PLAIN      = 2'd0;
	localparam logic [1:0] ROW_FADE_FIRST = 2'd1;
	localparam logic [1:0] ROW_FADE_LAST  = 2'd3;

	// Beat position inside a span of four output pixels.
	localparam logic [1:0] SPAN_LAST = 2'd3;

	// Register indexes (byte address / 4).
	localparam logic [2:0] REG_ACTIVE_WIDTH = 3'd0;
	localparam logic [2:0] REG_FADE_FIRST   = 3'd1;
	localparam logic [2:0] REG_FADE_LAST    = 3'd6;

	// Reset values of the registers.
	localparam logic [ACTIVE_W-1:0] ACTIVE_WIDTH_RESET = 11'd320;
	localparam logic [FADE_W-1:0] FADE_RESET [NUM_FADE] = '{
		17'd52429, 17'd58255, 17'd37450, 17'd43691, 17'd32768, 17'd36409
	};

	// Row 0 scanline masks.
	localparam logic [CH_W-1:0] MASK_EVEN = 8'hF8;
	localparam logic [CH_W-1:0] MASK_ODD  = 8'h07;

	// floor(x / 10) for x up to 2550 equals (x * 6554) >> 16.
	localparam int RECIP10_W = 13;
	localparam logic [RECIP10_W-1:0] RECIP10 = 13'd6554;
	localparam int RECIP10_SH = 16;

	// Fade factors are Q1.16.
	localparam int FADE_SH = 16;

	// Pixel: element 0 is red, 1 green, 2 blue (matches tdata order).
	typedef logic [2:0][CH_W-1:0] pix_t;

	typedef logic [NUM_FADE-1:0][FADE_W-1:0] fade_bank_t;

	// One output beat as handed from the span sequencer to the pixel pipe.
	typedef struct packed {
		pix_t                  c;
		pix_t                  n;
		logic [1:0]            k;
		logic [1:0]            row;
		logic [OUT_COL_W-1:0]  col;
		logic                  row_done;
		logic                  run_last;
	} beat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/crt4x_pix_pipe.sv -----
// ----------------------------------------------------------------------------
// CRT 4x pixel pipe
// Two-stage blend and scanline/fade pipeline ending in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module crt4x_pix_pipe (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  beat_valid,
	output logic                       beat_ready,
	input  wire crt4x_pkg::beat_t      beat,
	input  wire crt4x_pkg::fade_bank_t fade,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output crt4x_pkg::pix_t            out_pix,
	output logic [1:0]                 out_row,
	output logic [crt4x_pkg::OUT_COL_W-1:0] out_col,
	output logic                       out_row_done,
	output logic                       out_run_last
);

	localparam int SUM_W  = 12;
	localparam int PROD_W = SUM_W + crt4x_pkg::RECIP10_W;
	localparam int FPROD_W = crt4x_pkg::CH_W + crt4x_pkg::FADE_W;

	// Stage 1: blended pixel.
	logic                  v_p1_q;
	crt4x_pkg::pix_t       pix_s1;
	logic                  odd_s1;
	logic [1:0]            row_s1;
	logic [crt4x_pkg::OUT_COL_W-1:0] col_s1;
	logic                  row_done_s1;
	logic                  run_last_s1;

	logic                  adv_out;
	logic                  adv_s1;
	crt4x_pkg::pix_t       blend;
	crt4x_pkg::pix_t       shaded;

	logic [SUM_W-1:0]  sum_w;
	logic [PROD_W-1:0] prod_w [3];
	logic [crt4x_pkg::CH_W:0] avg_w [3];
	logic [FPROD_W-1:0] fprod [3];
	logic [crt4x_pkg::CH_W:0] fscaled [3];
	logic [crt4x_pkg::FADE_W-1:0] fsel;
	logic [2:0]            fidx;

	assign adv_out    = !out_valid || out_ready;
	assign adv_s1     = !v_p1_q || adv_out;
	assign beat_ready = adv_s1;

	// Blend of current and next pixel; the tenths use a reciprocal multiply.
	always_comb begin
		sum_w = '0;
		for (int ch = 0; ch < 3; ch++) begin
			if (beat.k == 2'd1) begin
				sum_w = SUM_W'(3 * beat.n[ch]) + SUM_W'(7 * beat.c[ch]);
			end else begin
				sum_w = SUM_W'(7 * beat.n[ch]) + SUM_W'(3 * beat.c[ch]);
			end
			prod_w[ch] = PROD_W'(sum_w) * PROD_W'(crt4x_pkg::RECIP10);
			avg_w[ch]  = {1'b0, beat.n[ch]} + {1'b0, beat.c[ch]};
			unique case (beat.k)
				2'd0: blend[ch] = beat.c[ch];
				2'd2: blend[ch] = avg_w[ch][crt4x_pkg::CH_W:1];
				default: begin
					blend[ch] = prod_w[ch][crt4x_pkg::RECIP10_SH +: crt4x_pkg::CH_W];
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_p1_q <= 1'b0;
		end else if (adv_s1) begin
			v_p1_q <= beat_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && beat_valid) begin
			pix_s1      <= blend;
			odd_s1      <= beat.k[0];
			row_s1      <= beat.row;
			col_s1      <= beat.col;
			row_done_s1 <= beat.row_done;
			run_last_s1 <= beat.run_last;
		end
	end

	// Stage 2: scanline mask on the first row, fade on the others.
	always_comb begin
		fidx = 3'({row_s1 - 2'd1, odd_s1});
		fsel = (row_s1 == crt4x_pkg::ROW_PLAIN) ? fade[0] : fade[fidx];
		for (int ch = 0; ch < 3; ch++) begin
			fprod[ch]   = FPROD_W'(pix_s1[ch]) * FPROD_W'(fsel);
			fscaled[ch] = fprod[ch][crt4x_pkg::FADE_SH +: crt4x_pkg::CH_W + 1];
			if (row_s1 == crt4x_pkg::ROW_PLAIN) begin
				shaded[ch] = odd_s1 ? (pix_s1[ch] | crt4x_pkg::MASK_ODD)
				                    : (pix_s1[ch] & crt4x_pkg::MASK_EVEN);
			end else if (fscaled[ch][crt4x_pkg::CH_W]) begin
				shaded[ch] = '1;
			end else begin
				shaded[ch] = fscaled[ch][crt4x_pkg::CH_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv_out) begin
			out_valid <= v_p1_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out && v_p1_q) begin
			out_pix      <= shaded;
			out_row      <= row_s1;
			out_col      <= col_s1;
			out_row_done <= row_done_s1;
			out_run_last <= run_last_s1;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/crt_scanline_upscaler_4x.sv -----
// ----------------------------------------------------------------------------
// CRT scanline upscaler 4x
// Expands each source pixel to four blended pixels and four scanline rows.
// ----------------------------------------------------------------------------
//
//  Channel   Group     Payload
//  --------  --------  ---------------------------------------------------
//  input     s_axis_*  tdata: red, green, blue; tuser: cmd (push/replay)
//  output    m_axis_*  tdata: red, green, blue, row, col; tuser: row_done;
//                      tlast: run_last
//  config    APB       7 registers at byte address 4*i, 32-bit data
//
// One pixel leaves per cycle unless the output stalls. A push or replay
// gives one span of four pixels; a push that closes a row of two or more
// pixels gives two. A first-column push that leaves the row open, or a
// dropped item, gives none. The first output beat passes the sequencer,
// stage-1 and output registers. Reset clears the control state only; the
// row store needs no clearing pass. A stalled output holds the pipe; a new
// item enters once the last beat of the current one is in the two-beat pipe.
//
`default_nettype none

module crt_scanline_upscaler_4x #(
	parameter int MAX_WIDTH = crt4x_pkg::MAX_WIDTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Input stream.
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,  // src_red, src_green, src_blue
	input  wire logic [0:0]  s_axis_tuser,  // cmd
	// Output stream.
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [39:0]      m_axis_tdata,  // out_red, out_green, out_blue,
	                                        // out_row, out_col, zero pad
	output logic [0:0]       m_axis_tuser,  // row_done
	output logic             m_axis_tlast,  // run_last
	// Configuration.
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [crt4x_pkg::PADDR_W-1:0] paddr,
	input  wire logic [crt4x_pkg::PDATA_W-1:0] pwdata,
	output logic [crt4x_pkg::PDATA_W-1:0] prdata,
	output logic             pready
);

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int CW    = (COL_W + 1 > crt4x_pkg::ACTIVE_W) ? COL_W + 1
	                                                         : crt4x_pkg::ACTIVE_W;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [crt4x_pkg::ACTIVE_W-1:0] active_width_q;
	crt4x_pkg::fade_bank_t          fade_q;
	logic [2:0]                     reg_idx;
	logic                           cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_width_q <= crt4x_pkg::ACTIVE_WIDTH_RESET;
			for (int i = 0; i < crt4x_pkg::NUM_FADE; i++) begin
				fade_q[i] <= crt4x_pkg::FADE_RESET[i];
			end
		end else if (cfg_wr) begin
			if (reg_idx == crt4x_pkg::REG_ACTIVE_WIDTH) begin
				active_width_q <= pwdata[crt4x_pkg::ACTIVE_W-1:0];
			end else if (reg_idx >= crt4x_pkg::REG_FADE_FIRST &&
			             reg_idx <= crt4x_pkg::REG_FADE_LAST) begin
				fade_q[reg_idx - crt4x_pkg::REG_FADE_FIRST] <=
					pwdata[crt4x_pkg::FADE_W-1:0];
			end
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_idx == crt4x_pkg::REG_ACTIVE_WIDTH) begin
			prdata = crt4x_pkg::PDATA_W'(active_width_q);
		end else if (reg_idx >= crt4x_pkg::REG_FADE_FIRST &&
		             reg_idx <= crt4x_pkg::REG_FADE_LAST) begin
			prdata = crt4x_pkg::PDATA_W'(fade_q[reg_idx - crt4x_pkg::REG_FADE_FIRST]);
		end
	end

	// Index of the last column: width clamped to 1..MAX_WIDTH, minus one.
	logic [CW-1:0]    aw_ext;
	logic [COL_W-1:0] last_col;

	assign aw_ext = CW'(active_width_q);

	always_comb begin
		if (aw_ext == '0) begin
			last_col = '0;
		end else if (aw_ext > CW'(MAX_WIDTH)) begin
			last_col = COL_W'(MAX_WIDTH - 1);
		end else begin
			last_col = COL_W'(aw_ext - CW'(1));
		end
	end

	// ------------------------------------------------------------------
	// Phase and column state
	// ------------------------------------------------------------------
	logic             replay_q;
	logic [1:0]       replay_row_q;
	logic [COL_W-1:0] replay_col_q;
	logic [COL_W-1:0] push_col_q;
	crt4x_pkg::pix_t  prev_pix_q;

	logic             in_fire;
	logic             take_push;
	logic             take_replay;
	crt4x_pkg::pix_t  in_pix;
	logic [COL_W-1:0] push_col;
	logic             push_last;
	logic [COL_W-1:0] rep_col;
	logic             rep_last;

	assign in_fire     = s_axis_tvalid && s_axis_tready;
	assign in_pix      = s_axis_tdata;
	// Items of the wrong phase are consumed and dropped.
	assign take_push   = in_fire && (s_axis_tuser[0] == crt4x_pkg::CMD_PUSH) && !replay_q;
	assign take_replay = in_fire && (s_axis_tuser[0] == crt4x_pkg::CMD_REPLAY) && replay_q;

	// A column past the current width (width shrunk mid-row) is the last one.
	assign push_col  = (push_col_q > last_col) ? last_col : push_col_q;
	assign push_last = (push_col == last_col);
	assign rep_col   = (replay_col_q > last_col) ? last_col : replay_col_q;
	assign rep_last  = (rep_col == last_col);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			replay_q     <= 1'b0;
			replay_row_q <= crt4x_pkg::ROW_FADE_FIRST;
			replay_col_q <= '0;
			push_col_q   <= '0;
			prev_pix_q   <= '0;
		end else if (take_push) begin
			prev_pix_q <= in_pix;
			if (push_last) begin
				push_col_q   <= '0;
				replay_q     <= 1'b1;
				replay_row_q <= crt4x_pkg::ROW_FADE_FIRST;
				replay_col_q <= '0;
			end else begin
				push_col_q <= push_col + COL_W'(1);
			end
		end else if (take_replay) begin
			if (rep_last) begin
				replay_col_q <= '0;
				if (replay_row_q == crt4x_pkg::ROW_FADE_LAST) begin
					replay_row_q <= crt4x_pkg::ROW_FADE_FIRST;
					replay_q     <= 1'b0;
				end else begin
					replay_row_q <= replay_row_q + 2'd1;
				end
			end else begin
				replay_col_q <= rep_col + COL_W'(1);
			end
		end
	end

	// ------------------------------------------------------------------
	// Row store: one write port (pushes), two registered read ports
	// (replays). A replay never reads in the cycle a push writes, since the
	// phases exclude each other, so no forwarding path is needed.
	// ------------------------------------------------------------------
	crt4x_pkg::pix_t  row_mem [MAX_WIDTH];
	crt4x_pkg::pix_t  rd_a_q;
	crt4x_pkg::pix_t  rd_b_q;
	logic [COL_W-1:0] rd_addr_b;

	assign rd_addr_b = rep_last ? rep_col : rep_col + COL_W'(1);

	always_ff @(posedge clk) begin
		if (take_push) begin
			row_mem[push_col] <= in_pix;
		end
		if (take_replay) begin
			rd_a_q <= row_mem[rep_col];
			rd_b_q <= row_mem[rd_addr_b];
		end
	end

	// ------------------------------------------------------------------
	// Span sequencer: walks the four beats of a span. A push that closes a
	// row wider than one pixel adds a span of the last pixel copied four times.
	// ------------------------------------------------------------------
	logic             v_s1_q;
	logic [1:0]       k_s1_q;
	logic             second_s1_q;
	logic             from_mem_s1;
	crt4x_pkg::pix_t  c_s1;
	crt4x_pkg::pix_t  n_s1;
	logic [COL_W-1:0] col_s1;
	logic [1:0]       row_s1;
	logic             lastcol_s1;

	logic             load_s1;
	logic             beat_ready;
	logic             beat_fire;
	logic             span_end;
	logic             item_done;
	crt4x_pkg::beat_t beat;
	logic [COL_W+1:0] out_pos;

	assign load_s1   = take_replay || (take_push && (push_col != '0 || push_last));
	assign beat_fire = v_s1_q && beat_ready;
	assign span_end  = (k_s1_q == crt4x_pkg::SPAN_LAST);
	assign item_done = beat_fire && span_end && !second_s1_q;

	assign s_axis_tready = !v_s1_q || item_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q      <= 1'b0;
			k_s1_q      <= '0;
			second_s1_q <= 1'b0;
		end else if (load_s1) begin
			v_s1_q      <= 1'b1;
			k_s1_q      <= '0;
			second_s1_q <= take_push && push_col != '0 && push_last;
		end else if (beat_fire) begin
			k_s1_q <= k_s1_q + 2'd1;
			if (span_end) begin
				if (second_s1_q) begin
					second_s1_q <= 1'b0;
				end else begin
					v_s1_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			if (take_replay) begin
				from_mem_s1 <= 1'b1;
				col_s1      <= rep_col;
				lastcol_s1  <= rep_last;
				row_s1      <= replay_row_q;
			end else if (push_col != '0) begin
				from_mem_s1 <= 1'b0;
				c_s1        <= prev_pix_q;
				n_s1        <= in_pix;
				col_s1      <= push_col - COL_W'(1);
				lastcol_s1  <= 1'b0;
				row_s1      <= crt4x_pkg::ROW_PLAIN;
			end else begin
				// A one-pixel row: only the copied span.
				from_mem_s1 <= 1'b0;
				c_s1        <= in_pix;
				n_s1        <= in_pix;
				col_s1      <= '0;
				lastcol_s1  <= 1'b1;
				row_s1      <= crt4x_pkg::ROW_PLAIN;
			end
		end else if (beat_fire && span_end && second_s1_q) begin
			c_s1       <= n_s1;
			col_s1     <= col_s1 + COL_W'(1);
			lastcol_s1 <= 1'b1;
		end
	end

	assign out_pos = {col_s1, k_s1_q};

	always_comb begin
		beat.c        = from_mem_s1 ? rd_a_q : c_s1;
		beat.n        = from_mem_s1 ? (lastcol_s1 ? rd_a_q : rd_b_q) : n_s1;
		beat.k        = k_s1_q;
		beat.row      = row_s1;
		beat.col      = crt4x_pkg::OUT_COL_W'(out_pos);
		beat.row_done = lastcol_s1 && span_end;
		beat.run_last = span_end && !second_s1_q;
	end

	// ------------------------------------------------------------------
	// Blend, scanline shading and output register
	// ------------------------------------------------------------------
	crt4x_pkg::pix_t                 out_pix;
	logic [1:0]                      out_row;
	logic [crt4x_pkg::OUT_COL_W-1:0] out_col;
	logic                            out_row_done;

	crt4x_pix_pipe u_pix_pipe (
		.clk          (clk),
		.arst_n       (arst_n),
		.beat_valid   (v_s1_q),
		.beat_ready   (beat_ready),
		.beat         (beat),
		.fade         (fade_q),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.out_pix      (out_pix),
		.out_row      (out_row),
		.out_col      (out_col),
		.out_row_done (out_row_done),
		.out_run_last (m_axis_tlast)
	);

	assign m_axis_tdata = {2'b00, out_col, out_row, out_pix};
	assign m_axis_tuser = out_row_done;

endmodule

`default_nettype wire

// ----- hw/rtl/crt4x_port_check.sv -----
// ----------------------------------------------------------------------------
// CRT 4x port checker
// Concurrent checks on the upscaler's output stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module crt4x_port_check (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [39:0] m_axis_tdata,
	input wire logic [0:0]  m_axis_tuser,
	input wire logic        m_axis_tlast
);

	// A stalled beat holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
			$stable(m_axis_tlast))
		else $error("output beat changed while stalled");

	// The end of a row is the fourth pixel of a span.
	a_row_done_col: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[27:26] == 2'b11)
		else $error("row end off the last pixel of a span");

	// The pixel that ends a row also ends the run of its input item.
	a_row_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
		else $error("row end not marked as run end");

	// First output row: even columns carry the dark scanline mask.
	a_row0_even: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[25:24] == crt4x_pkg::ROW_PLAIN && !m_axis_tdata[26]
		|-> (m_axis_tdata[7:0] & ~crt4x_pkg::MASK_EVEN) == 8'h00 &&
		    (m_axis_tdata[15:8] & ~crt4x_pkg::MASK_EVEN) == 8'h00 &&
		    (m_axis_tdata[23:16] & ~crt4x_pkg::MASK_EVEN) == 8'h00)
		else $error("even pixel of first row not masked");

	// First output row: odd columns carry the bright low bits.
	a_row0_odd: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[25:24] == crt4x_pkg::ROW_PLAIN && m_axis_tdata[26]
		|-> (m_axis_tdata[7:0] & crt4x_pkg::MASK_ODD) == crt4x_pkg::MASK_ODD &&
		    (m_axis_tdata[15:8] & crt4x_pkg::MASK_ODD) == crt4x_pkg::MASK_ODD &&
		    (m_axis_tdata[23:16] & crt4x_pkg::MASK_ODD) == crt4x_pkg::MASK_ODD)
		else $error("odd pixel of first row not brightened");

endmodule

bind crt_scanline_upscaler_4x crt4x_port_check u_port_check (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// ----- test/crt_scanline_upscaler_4x_test.sv -----
// ----------------------------------------------------------------------------
// CRT scanline upscaler 4x testbench
// Streams source pixels and row replays through the upscaler under random
// flow control, predicts every output pixel in a scoreboard and compares the
// results field by field. Registers are reprogrammed between traffic phases.
// ----------------------------------------------------------------------------

module crt_scanline_upscaler_4x_test;
	timeunit 1ns;
	timeprecision 1ps;

	import crt4x_pkg::*;

	// Number of source beats that the random part aims for. Dropped beats do
	// not count toward it.
	localparam int RUN_ITEMS = 280;
	// Hard stop for a hung run.
	localparam int LIMIT_CYCLES = 300000;
	// Quiet cycles after the last expected pixel, which cover work still
	// in flight.
	localparam int SETTLE_CYCLES = 12;
	localparam logic [FADE_W-1:0] FADE_ONE = 17'd65536;
	localparam logic [FADE_W-1:0] FADE_TOP = 17'h1FFFF;
	localparam logic [7:0] READY_PATTERN = 8'b1011_0110;

	// One output pixel as seen on the master side.
	typedef struct {
		logic [7:0]           red;
		logic [7:0]           green;
		logic [7:0]           blue;
		logic [1:0]           row;
		logic [OUT_COL_W-1:0] col;
		logic                 row_done;
		logic                 run_last;
	} out_pixel_t;

	// ------------------------------------------------------------------------
	// Scoreboard: keeps its own copy of the registers, the row store and the
	// push/replay sequencing, expands every accepted source beat into the
	// pixels it must produce and checks the output against them in order.
	// ------------------------------------------------------------------------
	class pixel_scoreboard;
		logic [ACTIVE_W-1:0] width_reg;
		logic [FADE_W-1:0]   fade [NUM_FADE];
		pix_t                row_copy [MAX_WIDTH_DEF];
		bit                  line_written [MAX_WIDTH_DEF];
		pix_t                prev_pix;
		int unsigned         push_col;
		int unsigned         replay_col;
		bit                  replaying;
		logic [1:0]          replay_row;
		out_pixel_t          pending_pixels [$];
		int                  errors;

		function new();
			width_reg = ACTIVE_WIDTH_RESET;
			for (int i = 0; i < NUM_FADE; i++) fade[i] = FADE_RESET[i];
			prev_pix = '0;
			push_col = 0;
			replay_col = 0;
			replaying = 1'b0;
			replay_row = ROW_FADE_FIRST;
			errors = 0;
		endfunction

		// Width 0 behaves as one pixel, anything past the store depth as the
		// full store.
		function int unsigned line_len(logic [ACTIVE_W-1:0] w);
			if (w == 0) return 1;
			if (w > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
			return w;
		endfunction

		// Widening the line during replay would read store entries that were
		// never written, which the block leaves undefined.
		function bit width_is_safe(logic [ACTIVE_W-1:0] w);
			if (!replaying) return 1'b1;
			for (int i = 0; i < line_len(w); i++)
				if (!line_written[i]) return 1'b0;
			return 1'b1;
		endfunction

		function void write_reg(logic [2:0] idx, logic [31:0] val);
			if (idx == REG_ACTIVE_WIDTH) width_reg = val[ACTIVE_W-1:0];
			else fade[idx - REG_FADE_FIRST] = val[FADE_W-1:0];
		endfunction

		function logic [31:0] read_reg(logic [2:0] idx);
			if (idx == REG_ACTIVE_WIDTH) return 32'(width_reg);
			return 32'(fade[idx - REG_FADE_FIRST]);
		endfunction

		// Blend, then either apply the scanline mask (row 0) or the fade.
		function logic [7:0] expand_channel(logic [7:0] c, logic [7:0] n, logic [1:0] k,
				logic [1:0] row, logic [FADE_W-1:0] f);
			int unsigned v;
			int unsigned cu;
			int unsigned nu;
			cu = 32'(c);
			nu = 32'(n);
			case (k)
				2'd0: v = cu;
				2'd1: v = (3 * nu + 7 * cu) / 10;
				2'd2: v = (nu + cu) >> 1;
				default: v = (7 * nu + 3 * cu) / 10;
			endcase
			if (row == ROW_PLAIN) begin
				v = k[0] ? (v | 32'(MASK_ODD)) : (v & 32'(MASK_EVEN));
			end else begin
				v = (v * 32'(f)) >> FADE_SH;
				if (v > 255) v = 255;
			end
			return v[7:0];
		endfunction

		function void add_span(pix_t c, pix_t n, logic [1:0] row, int unsigned col,
				bit last_col);
			out_pixel_t p;
			logic [FADE_W-1:0] f;
			logic [1:0] k;
			for (int kk = 0; kk < 4; kk++) begin
				k = 2'(kk);
				f = '0;
				if (row != ROW_PLAIN)
					f = fade[2 * (int'(row) - int'(ROW_FADE_FIRST)) + int'(k[0])];
				p.red = expand_channel(c[0], n[0], k, row, f);
				p.green = expand_channel(c[1], n[1], k, row, f);
				p.blue = expand_channel(c[2], n[2], k, row, f);
				p.row = row;
				p.col = OUT_COL_W'(4 * col + kk);
				p.row_done = last_col && (k == SPAN_LAST);
				p.run_last = 1'b0;
				pending_pixels.push_back(p);
			end
		endfunction

		// Notes one accepted source beat. Returns 0 when the block drops it
		// because it arrived in the wrong phase.
		function bit take_source_beat(logic cmd, pix_t pix);
			int unsigned w;
			int unsigned queued;
			bit last;
			w = line_len(width_reg);
			queued = pending_pixels.size();
			if (cmd == CMD_PUSH) begin
				if (replaying) return 1'b0;
				if (push_col >= w) push_col = w - 1;
				last = (push_col >= w - 1);
				row_copy[push_col] = pix;
				line_written[push_col] = 1'b1;
				if (push_col > 0) add_span(prev_pix, pix, ROW_PLAIN, push_col - 1, 1'b0);
				if (last) begin
					add_span(pix, pix, ROW_PLAIN, push_col, 1'b1);
					push_col = 0;
					replaying = 1'b1;
					replay_row = ROW_FADE_FIRST;
					replay_col = 0;
				end else begin
					push_col++;
				end
				prev_pix = pix;
			end else begin
				if (!replaying) return 1'b0;
				if (replay_col >= w) replay_col = w - 1;
				last = (replay_col >= w - 1);
				add_span(row_copy[replay_col], last ? row_copy[replay_col] : row_copy[replay_col + 1],
					replay_row, replay_col, last);
				if (last) begin
					replay_col = 0;
					if (replay_row == ROW_FADE_LAST) begin
						replay_row = ROW_FADE_FIRST;
						replaying = 1'b0;
					end else begin
						replay_row++;
					end
				end else begin
					replay_col++;
				end
			end
			if (pending_pixels.size() > queued) pending_pixels[$].run_last = 1'b1;
			return 1'b1;
		endfunction

		function void compare(string name, logic [OUT_COL_W-1:0] want, logic [OUT_COL_W-1:0] got);
			if (got !== want) begin
				$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
				errors++;
			end
		endfunction

		function void check_pixel(out_pixel_t got);
			out_pixel_t want;
			if (pending_pixels.size() == 0) begin
				$error("output beat with nothing expected: row %0d col %0d", got.row, got.col);
				errors++;
				return;
			end
			want = pending_pixels.pop_front();
			compare("out_red", want.red, got.red);
			compare("out_green", want.green, got.green);
			compare("out_blue", want.blue, got.blue);
			compare("out_row", want.row, got.row);
			compare("out_col", want.col, got.col);
			compare("row_done", want.row_done, got.row_done);
			compare("run_last", want.run_last, got.run_last);
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Clock, reset and the block's ports. Every input starts at a known value.
	// ------------------------------------------------------------------------
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [23:0] s_axis_tdata = '0;  // src_red, src_green, src_blue
	logic [0:0] s_axis_tuser = '0;   // cmd
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;       // out_red, out_green, out_blue, out_row,
	                                 // out_col, zero pad
	logic [0:0] m_axis_tuser;        // row_done
	logic m_axis_tlast;              // run_last
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	pixel_scoreboard sb = new();

	// Sender pacing: beats leave in bursts, and a burst ends in a gap.
	int burst_left = 0;
	logic [9:0] ready_tick = '0;

	crt_scanline_upscaler_4x dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// The receiver cycles through four stall styles in turn: always ready,
	// mostly ready, a fixed on/off pattern and heavy back-pressure.
	always @(posedge clk) begin
		ready_tick <= ready_tick + 1'b1;
		case (ready_tick[9:8])
			2'd0: m_axis_tready <= 1'b1;
			2'd1: m_axis_tready <= ($urandom_range(0, 9) < 7);
			2'd2: m_axis_tready <= READY_PATTERN[ready_tick[2:0]];
			default: m_axis_tready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	// Every output beat is checked at the edge that accepts it. The values
	// sampled here are the ones the block saw at that edge.
	always @(posedge clk) begin : output_monitor
		out_pixel_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.red = m_axis_tdata[7:0];
			got.green = m_axis_tdata[15:8];
			got.blue = m_axis_tdata[23:16];
			got.row = m_axis_tdata[25:24];
			got.col = m_axis_tdata[37:26];
			got.row_done = m_axis_tuser[0];
			got.run_last = m_axis_tlast;
			sb.check_pixel(got);
		end
	end

	// A hung handshake ends the run here.
	initial begin : watchdog
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("crt_scanline_upscaler_4x: mismatch");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Drivers. All of them are entered and left at a rising edge.
	// ------------------------------------------------------------------------
	function automatic pix_t make_pix(logic [7:0] r, logic [7:0] g, logic [7:0] b);
		return {b, g, r};
	endfunction

	// Random colors, with each channel pinned to 0x00 or 0xFF now and then.
	function automatic pix_t random_pix();
		pix_t p;
		for (int ch = 0; ch < 3; ch++) begin
			case ($urandom_range(0, 9))
				0: p[ch] = 8'h00;
				1: p[ch] = 8'hFF;
				default: p[ch] = 8'($urandom_range(0, 255));
			endcase
		end
		return p;
	endfunction

	// Presents one source beat, waits for the handshake and tells the
	// scoreboard. When the burst runs out, valid drops for a random gap.
	task automatic send_beat(logic cmd, pix_t pix, output bit taken);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= cmd;
		s_axis_tdata <= pix;
		do @(posedge clk); while (!s_axis_tready);
		taken = sb.take_source_beat(cmd, pix);
		if (burst_left == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 5) == 0) ? 48 : $urandom_range(0, 10);
		end else begin
			burst_left--;
		end
	endtask

	// Holds the sender until every expected pixel is out, then lets beats
	// that made no pixels (dropped ones, first-column pushes) finish too.
	task automatic drain_and_settle();
		s_axis_tvalid <= 1'b0;
		while (sb.pending_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// APB write followed by a read-back of the same register, then the bus
	// is left idle.
	task automatic program_reg(logic [2:0] idx, logic [31:0] val);
		logic [PDATA_W-1:0] got;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.write_reg(idx, val);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		got = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		if (got !== sb.read_reg(idx)) begin
			$error("prdata: expected 0x%0h, got 0x%0h", sb.read_reg(idx), got);
			sb.errors++;
		end
		@(posedge clk);
	endtask

	// Rewrites a few random registers. Fades cover zero, unity, the top of
	// the 17-bit range (which saturates) and everything in between. Widths
	// are mostly small so rows close often; rare huge ones get cut short by
	// the next reprogramming, which shrinks the line in the middle of a row.
	task automatic random_config();
		logic [2:0] idx;
		logic [ACTIVE_W-1:0] w;
		logic [FADE_W-1:0] f;
		repeat ($urandom_range(1, 4)) begin
			idx = 3'($urandom_range(REG_ACTIVE_WIDTH, REG_FADE_LAST));
			if (idx == REG_ACTIVE_WIDTH) begin
				case ($urandom_range(0, 19))
					0: w = '0;
					1: w = '1;
					2: w = ACTIVE_W'(MAX_WIDTH_DEF);
					3, 4: w = ACTIVE_W'($urandom_range(9, 24));
					default: w = ACTIVE_W'($urandom_range(1, 8));
				endcase
				if (sb.width_is_safe(w)) program_reg(idx, 32'(w));
			end else begin
				case ($urandom_range(0, 7))
					0: f = '0;
					1: f = FADE_ONE;
					2: f = FADE_TOP;
					3: f = FADE_W'($urandom_range(FADE_ONE + 1, FADE_TOP));
					default: f = FADE_W'($urandom_range(0, FADE_ONE));
				endcase
				program_reg(idx, 32'(f));
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Main sequence.
	// ------------------------------------------------------------------------
	initial begin : main_sequence
		bit taken;
		logic cmd;
		int done_items;
		int since_config;
		int config_every;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset width and fades. Three pushes of a 320-pixel row, with a
		// replay in between that must be dropped since the block is pushing.
		send_beat(CMD_PUSH, make_pix(8'hFF, 8'hFF, 8'hFF), taken);
		send_beat(CMD_PUSH, make_pix(8'h00, 8'h00, 8'h00), taken);
		send_beat(CMD_REPLAY, random_pix(), taken);
		send_beat(CMD_PUSH, make_pix(8'hC3, 8'h5A, 8'hA5), taken);

		// Shrinking the line to three pixels turns the next push into the
		// row's last pixel: its left span plus four copies of itself. A push
		// during replay is dropped, then three rows fade with reset factors.
		drain_and_settle();
		program_reg(REG_ACTIVE_WIDTH, 32'd3);
		send_beat(CMD_PUSH, make_pix(8'h12, 8'hFE, 8'h01), taken);
		send_beat(CMD_PUSH, random_pix(), taken);
		repeat (9) send_beat(CMD_REPLAY, random_pix(), taken);

		// Width 0 acts as a single pixel. Fades at zero, unity, the 17-bit
		// maximum and other odd points, so the faded rows saturate too.
		drain_and_settle();
		program_reg(REG_ACTIVE_WIDTH, 32'd0);
		program_reg(3'(REG_FADE_FIRST + 0), 32'd0);
		program_reg(3'(REG_FADE_FIRST + 1), 32'(FADE_ONE));
		program_reg(3'(REG_FADE_FIRST + 2), 32'(FADE_TOP));
		program_reg(3'(REG_FADE_FIRST + 3), 32'd65535);
		program_reg(3'(REG_FADE_FIRST + 4), 32'd1);
		program_reg(3'(REG_FADE_FIRST + 5), 32'd100000);
		send_beat(CMD_PUSH, make_pix(8'hFF, 8'h80, 8'h01), taken);
		repeat (3) send_beat(CMD_REPLAY, random_pix(), taken);

		// Largest width register value, clamped to the store depth, then cut
		// to one pixel in mid-row: the third push lands on column 0 again.
		drain_and_settle();
		program_reg(REG_ACTIVE_WIDTH, 32'h7FF);
		send_beat(CMD_PUSH, make_pix(8'h0F, 8'hF0, 8'hFF), taken);
		send_beat(CMD_PUSH, make_pix(8'hF0, 8'h0F, 8'h00), taken);
		drain_and_settle();
		program_reg(REG_ACTIVE_WIDTH, 32'd1);
		send_beat(CMD_PUSH, random_pix(), taken);
		repeat (3) send_beat(CMD_REPLAY, random_pix(), taken);

		// Random part: mostly the command the block is waiting for, with
		// some wrong-phase noise, and regular stops to reprogram registers
		// wherever the row happens to be.
		drain_and_settle();
		random_config();
		done_items = 0;
		since_config = 0;
		config_every = 30;
		while (done_items < RUN_ITEMS) begin
			if (since_config >= config_every) begin
				drain_and_settle();
				random_config();
				since_config = 0;
				config_every = $urandom_range(20, 60);
			end
			if ($urandom_range(0, 99) < 88) cmd = sb.replaying ? CMD_REPLAY : CMD_PUSH;
			else cmd = 1'($urandom_range(0, 1));
			send_beat(cmd, random_pix(), taken);
			if (taken) begin
				done_items++;
				since_config++;
			end
		end

		drain_and_settle();
		if (sb.pending_pixels.size() != 0) begin
			$error("%0d expected pixels never arrived", sb.pending_pixels.size());
			sb.errors++;
		end
		if (sb.errors == 0) begin
			$display("crt_scanline_upscaler_4x: match");
		end else begin
			$display("crt_scanline_upscaler_4x: mismatch");
		end
		$finish;
	end

endmodule
